@@ hdl/symbol_pool_free_stack_allocator_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the symbol pool allocator
// Concurrent checks that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SYMBOL_POOL_FREE_STACK_ALLOCATOR_UNIT_ASSERT_SVH
`define SYMBOL_POOL_FREE_STACK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define SPFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SPFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SPFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/spfa_pkg.sv @@
// ---------------------------------------------------------------------------
// spfa_pkg
// Shared types and constants of the symbol pool allocator.
// ---------------------------------------------------------------------------
package spfa_pkg;

    localparam int SLOT_W   = 10;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 16;
    localparam int OP_W     = 2;
    localparam int APB_W    = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_RECYCLE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 16'd256;

    // register index 0, word decoded on paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GRANT,
        ST_FINISH
    } spfa_state_t;

    typedef struct packed {
        logic capture;
        logic grant;
        logic finish;
    } spfa_cmd_t;

    typedef struct packed {
        logic alloc_req;
    } spfa_status_t;

endpackage

@@ hdl/spfa_ctrl.sv @@
// ---------------------------------------------------------------------------
// spfa_ctrl
// Sequencer: accepts a command, steps the datapath, raises the result strobe.
// ---------------------------------------------------------------------------
`include "symbol_pool_free_stack_allocator_unit_assert.svh"

module spfa_ctrl
    import spfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  spfa_status_t status,
    output spfa_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    spfa_state_t state_reg;
    spfa_state_t state_next;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.grant   = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.alloc_req ? ST_GRANT : ST_FINISH;
                end
            end
            ST_GRANT:
            begin
                cmd.grant  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    `SPFA_ASSERT_NXT(a_alloc_grants, clk, rst_n, cmd.capture && status.alloc_req,
        state_reg == ST_GRANT, "allocate did not enter grant step")
    `SPFA_ASSERT_NXT(a_grant_finishes, clk, rst_n, state_reg == ST_GRANT,
        state_reg == ST_FINISH, "grant step not followed by finish")
    `SPFA_ASSERT_NXT(a_finish_strobes, clk, rst_n, state_reg == ST_FINISH,
        done_reg && !busy, "finish did not produce a single result strobe")

endmodule

@@ hdl/spfa_datapath.sv @@
// ---------------------------------------------------------------------------
// spfa_datapath
// Free stack, bump pointer, link and reference count memories, result regs.
// ---------------------------------------------------------------------------
`include "symbol_pool_free_stack_allocator_unit_assert.svh"

module spfa_datapath
    import spfa_pkg::*;
#(
    parameter int POOL_SLOTS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  spfa_cmd_t           cmd,
    output spfa_status_t        status,
    input  logic [VALUE_W-1:0]  threshold,
    input  logic [OP_W-1:0]     operation,
    input  logic [VALUE_W-1:0]  symbol_value,
    input  logic                rule_present,
    input  logic [SLOT_W-1:0]   rule_slot,
    input  logic [SLOT_W-1:0]   recycle_slot,
    output logic [SLOT_W-1:0]   slot,
    output logic                exhausted,
    output logic [COUNT_W-1:0]  rule_count
);

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);

    // captured transaction
    logic [OP_W-1:0]     op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                rule_present_reg;
    logic [SLOT_W-1:0]   rule_slot_reg;
    logic [SLOT_W-1:0]   recycle_slot_reg;

    // pool state
    logic [CNT_W-1:0]    used_count_reg;
    logic [IDX_W-1:0]    free_head_reg;
    logic                free_valid_reg;

    // memory read data
    logic [IDX_W:0]      link_rd_reg;
    logic [COUNT_W-1:0]  count_rd_reg;

    // grant step results
    logic [IDX_W-1:0]    granted_reg;
    logic                granted_ok_reg;
    logic                rule_ok_reg;
    logic [COUNT_W-1:0]  count_reg;

    // result registers
    logic [SLOT_W-1:0]   slot_reg;
    logic                exhausted_reg;
    logic [COUNT_W-1:0]  rule_count_reg;

    logic [IDX_W:0]      link_mem [POOL_SLOTS];
    logic [COUNT_W-1:0]  cnt_mem  [POOL_SLOTS];

    logic                pop;
    logic                bump_ok;
    logic                grant_ok;
    logic [IDX_W-1:0]    grant_idx;
    logic [IDX_W-1:0]    rule_idx;
    logic                rule_in_pool;
    logic                rule_ok;
    logic [COUNT_W-1:0]  count_next;
    logic [IDX_W-1:0]    recycle_idx;
    logic                recycle_in_pool;

    logic                cnt_we;
    logic [IDX_W-1:0]    cnt_waddr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic                link_we;

    assign status.alloc_req = (operation == OP_ALLOC);

    assign pop          = free_valid_reg;
    assign bump_ok      = (used_count_reg < CNT_W'(POOL_SLOTS));
    assign grant_ok     = pop || bump_ok;
    assign grant_idx    = pop ? free_head_reg : IDX_W'(used_count_reg);
    assign rule_idx     = IDX_W'(rule_slot_reg);
    assign rule_in_pool = (32'(rule_slot_reg) < 32'(POOL_SLOTS));
    assign rule_ok      = grant_ok && rule_present_reg && rule_in_pool &&
                          (value_reg >= threshold);

    always_comb
    begin
        if (rule_idx == grant_idx)
        begin
            count_next = COUNT_W'(1);
        end
        else if (count_rd_reg == COUNT_MAX)
        begin
            count_next = COUNT_MAX;
        end
        else
        begin
            count_next = count_rd_reg + COUNT_W'(1);
        end
    end

    assign recycle_idx     = IDX_W'(recycle_slot_reg);
    assign recycle_in_pool = (32'(recycle_slot_reg) < 32'(POOL_SLOTS));
    assign link_we         = cmd.finish && (op_reg == OP_RECYCLE) && recycle_in_pool;

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = grant_idx;
        cnt_wdata = '0;
        if (cmd.grant && grant_ok)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.finish && (op_reg == OP_ALLOC) && rule_ok_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = rule_idx;
            cnt_wdata = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            link_rd_reg  <= link_mem[free_head_reg];
            count_rd_reg <= cnt_mem[IDX_W'(rule_slot)];
        end
        if (link_we)
        begin
            link_mem[recycle_idx] <= free_valid_reg ? {1'b1, free_head_reg} : '0;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg           <= operation;
            value_reg        <= symbol_value;
            rule_present_reg <= rule_present;
            rule_slot_reg    <= rule_slot;
            recycle_slot_reg <= recycle_slot;
        end
        if (cmd.grant)
        begin
            granted_reg    <= grant_idx;
            granted_ok_reg <= grant_ok;
            rule_ok_reg    <= rule_ok;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
            free_head_reg  <= '0;
            free_valid_reg <= 1'b0;
            slot_reg       <= '0;
            exhausted_reg  <= 1'b0;
            rule_count_reg <= '0;
        end
        else
        begin
            if (cmd.grant)
            begin
                if (pop)
                begin
                    free_head_reg  <= link_rd_reg[IDX_W-1:0];
                    free_valid_reg <= link_rd_reg[IDX_W];
                end
                else if (bump_ok)
                begin
                    used_count_reg <= CNT_W'(used_count_reg + 1'b1);
                end
            end
            if (cmd.finish)
            begin
                slot_reg       <= ((op_reg == OP_ALLOC) && granted_ok_reg) ?
                                  SLOT_W'(granted_reg) : '0;
                exhausted_reg  <= (op_reg == OP_ALLOC) && !granted_ok_reg;
                rule_count_reg <= ((op_reg == OP_ALLOC) && rule_ok_reg) ? count_reg : '0;
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        used_count_reg <= '0;
                        free_head_reg  <= '0;
                        free_valid_reg <= 1'b0;
                    end
                    OP_RECYCLE:
                    begin
                        if (recycle_in_pool)
                        begin
                            free_head_reg  <= recycle_idx;
                            free_valid_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign slot       = slot_reg;
    assign exhausted  = exhausted_reg;
    assign rule_count = rule_count_reg;

    `SPFA_ASSERT_IMP(a_exhausted_clean, clk, rst_n, exhausted_reg,
        (slot_reg == '0) && (rule_count_reg == '0), "exhausted result carries data")
    `SPFA_ASSERT_NXT(a_exhausted_no_change, clk, rst_n, cmd.grant && !grant_ok,
        $stable(used_count_reg) && !free_valid_reg, "pool state moved on exhaustion")
    `SPFA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1,
        used_count_reg <= CNT_W'(POOL_SLOTS), "bump pointer ran past pool")

endmodule

@@ hdl/symbol_pool_free_stack_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// symbol_pool_free_stack_allocator_unit
// Slot pool with a LIFO free stack, bump pointer and reference counts.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation and its fields with start high; the
//   transaction is taken on a rising edge with start high and busy low.
//   Operations: clear the pool, allocate a slot, recycle a slot.
//   Result channel: slot, exhausted and rule_count are valid for exactly one
//   cycle while done is high. The receiver cannot stall; every transaction
//   gives one result.
//   Sequence: allocate passes through a grant step and a finish step before
//   done rises; clear and recycle go straight to the finish step. busy is
//   high until the finish step is over, so no new transaction is taken
//   before the last one is through. Allocate needs its grant step for the
//   registered read of the link and count memories followed by a clear of the
//   granted count and a write of the rule count on their one write port.
//   APB: register 0 (byte address 0) holds the 16-bit nonterminal threshold;
//   write it only while no transaction is in flight.
//   Reset: pool empty, free stack empty, threshold 256. The link and count
//   memories are not cleared; counts of slots never granted are undefined.
// ---------------------------------------------------------------------------
module symbol_pool_free_stack_allocator_unit
    import spfa_pkg::*;
#(
    parameter int POOL_SLOTS = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        operation,
    input  logic [VALUE_W-1:0]     symbol_value,
    input  logic                   rule_present,
    input  logic [SLOT_W-1:0]      rule_slot,
    input  logic [SLOT_W-1:0]      recycle_slot,
    output logic                   done,
    output logic [SLOT_W-1:0]      slot,
    output logic                   exhausted,
    output logic [COUNT_W-1:0]     rule_count,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]       pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready
);

    spfa_cmd_t           cmd;
    spfa_status_t        status;
    logic [VALUE_W-1:0]  threshold_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            threshold_reg <= pwdata[VALUE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_W'(threshold_reg) : '0;

    spfa_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    spfa_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .threshold    (threshold_reg),
        .operation    (operation),
        .symbol_value (symbol_value),
        .rule_present (rule_present),
        .rule_slot    (rule_slot),
        .recycle_slot (recycle_slot),
        .slot         (slot),
        .exhausted    (exhausted),
        .rule_count   (rule_count)
    );

endmodule

@@ sim/symbol_pool_free_stack_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Symbol pool allocator testbench
// Drives clear, allocate, recycle and unused commands into the slot pool and checks
// every granted slot, exhaustion flag and rule count against a shadow copy of
// the free stack, bump pointer and reference counts. Covers directed corner
// cases and random traffic under several thresholds.
// ---------------------------------------------------------------------------
module symbol_pool_free_stack_allocator_unit_tb;
    import spfa_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int POOL_SLOTS     = 1024;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int BATCH_ITEMS    = 215;

    localparam logic [OP_W-1:0]       OP_UNUSED      = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               exhausted;
        logic [COUNT_W-1:0] rule_count;
    } slot_grant_t;

    class pool_grant_tracker;
        logic [VALUE_W-1:0] threshold;
        int                 used_slots;
        logic [SLOT_W-1:0]  stack_top;
        bit                 stack_valid;
        logic [SLOT_W:0]    link_mem [POOL_SLOTS];
        logic [COUNT_W-1:0] count_mem [POOL_SLOTS];
        bit                 count_defined [POOL_SLOTS];
        slot_grant_t        pending_grants [$];
        int                 mismatch_count;

        function new();
            threshold      = THRESHOLD_RESET;
            used_slots     = 0;
            stack_top      = '0;
            stack_valid    = 1'b0;
            mismatch_count = 0;
            foreach (count_defined[i])
                count_defined[i] = 1'b0;
        endfunction

        function int next_grant();
            if (stack_valid)
                return int'(stack_top);
            if (used_slots < POOL_SLOTS)
                return used_slots;
            return -1;
        endfunction

        function bit rule_safe(logic [SLOT_W-1:0] rule);
            int upcoming;
            upcoming = next_grant();
            return upcoming < 0 || count_defined[rule] || int'(rule) == upcoming;
        endfunction

        function slot_grant_t note_command(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                           logic with_rule, logic [SLOT_W-1:0] rule,
                                           logic [SLOT_W-1:0] freed);
            slot_grant_t outcome;
            int          granted;
            outcome = '0;
            case (op)
                OP_CLEAR:
                begin
                    used_slots  = 0;
                    stack_top   = '0;
                    stack_valid = 1'b0;
                end
                OP_ALLOC:
                begin
                    granted = next_grant();
                    if (granted < 0)
                        outcome.exhausted = 1'b1;
                    else
                    begin
                        if (stack_valid)
                        begin
                            stack_top   = link_mem[granted][SLOT_W-1:0];
                            stack_valid = link_mem[granted][SLOT_W];
                        end
                        else
                            used_slots++;
                        outcome.slot             = granted[SLOT_W-1:0];
                        count_mem[granted]     = '0;
                        count_defined[granted] = 1'b1;
                        if (with_rule && value >= threshold)
                        begin
                            if (count_mem[rule] != COUNT_MAX)
                                count_mem[rule]++;
                            outcome.rule_count = count_mem[rule];
                        end
                    end
                end
                OP_RECYCLE:
                begin
                    link_mem[freed] = stack_valid ? {1'b1, stack_top} : '0;
                    stack_top       = freed;
                    stack_valid     = 1'b1;
                end
                default:
                    ;
            endcase
            pending_grants.push_back(outcome);
            return outcome;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_result(logic [SLOT_W-1:0] got_slot, logic got_exhausted,
                          logic [COUNT_W-1:0] got_count);
            slot_grant_t want;
            if (pending_grants.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: slot %0d exhausted %0b count %0d",
                                          got_slot, got_exhausted, got_count));
                return;
            end
            want = pending_grants.pop_front();
            if (got_slot !== want.slot)
                report_mismatch($sformatf("slot %0d, want %0d", got_slot, want.slot));
            if (got_exhausted !== want.exhausted)
                report_mismatch($sformatf("exhausted %0b, want %0b", got_exhausted, want.exhausted));
            if (got_count !== want.rule_count)
                report_mismatch($sformatf("rule_count %0d, want %0d", got_count, want.rule_count));
        endtask
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       operation    = OP_CLEAR;
    logic [VALUE_W-1:0]    symbol_value = '0;
    logic                  rule_present = 1'b0;
    logic [SLOT_W-1:0]     rule_slot    = '0;
    logic [SLOT_W-1:0]     recycle_slot = '0;
    logic                  done;
    logic [SLOT_W-1:0]     slot;
    logic                  exhausted;
    logic [COUNT_W-1:0]    rule_count;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [APB_W-1:0]      pwdata       = '0;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    pool_grant_tracker     tracker      = new();
    logic [SLOT_W-1:0]     live_slots [$];
    int                    idle_cycles  = 0;

    symbol_pool_free_stack_allocator_unit #(
        .POOL_SLOTS   (POOL_SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .symbol_value (symbol_value),
        .rule_present (rule_present),
        .rule_slot    (rule_slot),
        .recycle_slot (recycle_slot),
        .done         (done),
        .slot         (slot),
        .exhausted    (exhausted),
        .rule_count   (rule_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            tracker.check_result(slot, exhausted, rule_count);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                input logic with_rule, input logic [SLOT_W-1:0] rule,
                                input logic [SLOT_W-1:0] freed);
        slot_grant_t predicted;
        start        <= 1'b1;
        operation    <= op;
        symbol_value <= value;
        rule_present <= with_rule;
        rule_slot    <= rule;
        recycle_slot <= freed;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = tracker.note_command(op, value, with_rule, rule, freed);
        if (op == OP_ALLOC && !predicted.exhausted)
            live_slots.push_back(predicted.slot);
        else if (op == OP_CLEAR)
            live_slots.delete();
    endtask

    task automatic idle_gap();
        int pick;
        int cycles;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            cycles = 0;
        else if (pick < 85)
            cycles = $urandom_range(1, 3);
        else if (pick < 97)
            cycles = $urandom_range(4, 12);
        else
            cycles = $urandom_range(20, 40);
        if (cycles != 0)
        begin
            start <= 1'b0;
            repeat (cycles)
                @(posedge clk);
        end
    endtask

    task automatic send_random(input bit alloc_only);
        int                 pick;
        int                 idx;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic               with_rule;
        logic [SLOT_W-1:0]  rule;
        logic [SLOT_W-1:0]  freed;
        pick = alloc_only ? 10 : $urandom_range(0, 99);
        if (pick < 2)
            op = OP_CLEAR;
        else if (pick < 4)
            op = OP_UNUSED;
        else if (pick < 60)
            op = OP_ALLOC;
        else
            op = OP_RECYCLE;
        if ($urandom_range(0, 1) == 1)
            value = VALUE_W'($urandom_range(int'(tracker.threshold), 16'hFFFF));
        else
            value = VALUE_W'($urandom);
        with_rule = ($urandom_range(0, 3) != 0);
        rule      = SLOT_W'($urandom);
        if (live_slots.size() != 0 && $urandom_range(0, 3) != 0)
            rule = live_slots[$urandom_range(0, live_slots.size() - 1)];
        freed = SLOT_W'($urandom);
        if (op == OP_RECYCLE && live_slots.size() != 0 && $urandom_range(0, 9) != 0)
        begin
            idx   = $urandom_range(0, live_slots.size() - 1);
            freed = live_slots[idx];
            live_slots.delete(idx);
        end
        // drop the rule where its count was never written
        if (op == OP_ALLOC && with_rule && value >= tracker.threshold && !tracker.rule_safe(rule))
            with_rule = 1'b0;
        send_command(op, value, with_rule, rule, freed);
    endtask

    task automatic run_batch(input int items);
        bit steady;
        steady = 1'b0;
        for (int i = 0; i < items; i++)
        begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_random(1'b0);
            if (!steady)
                idle_gap();
        end
    endtask

    task automatic settle_pool();
        start <= 1'b0;
        while (tracker.pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [VALUE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THRESHOLD_ADDR;
        pwdata  <= APB_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        tracker.threshold = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== APB_W'(value))
            tracker.report_mismatch($sformatf("threshold read %0h, want %0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        send_command(OP_UNUSED, 16'hFFFF, 1'b1, 10'h3FF, 10'h3FF); idle_gap();
        send_command(OP_ALLOC, 16'h0000, 1'b0, 10'd0, 10'd0);      idle_gap();
        send_command(OP_ALLOC, 16'hFFFF, 1'b1, 10'd1, 10'd0);      idle_gap();
        send_command(OP_ALLOC, THRESHOLD_RESET, 1'b1, 10'd0, 10'd0); idle_gap();
        send_command(OP_ALLOC, VALUE_W'(THRESHOLD_RESET - 1), 1'b1, 10'd0, 10'd0); idle_gap();
        send_command(OP_ALLOC, 16'hFFFF, 1'b0, 10'd0, 10'd0);      idle_gap();
        send_command(OP_RECYCLE, 16'h0000, 1'b0, 10'd0, 10'd2);    idle_gap();
        send_command(OP_RECYCLE, 16'h0000, 1'b0, 10'd0, 10'h3FF);  idle_gap();
        send_command(OP_RECYCLE, 16'h0000, 1'b0, 10'd0, 10'd2);    idle_gap();
        send_command(OP_ALLOC, 16'd1000, 1'b1, 10'd0, 10'd0);      idle_gap();
        send_command(OP_ALLOC, 16'd1000, 1'b1, 10'h3FF, 10'd0);    idle_gap();
        send_command(OP_ALLOC, 16'h0000, 1'b0, 10'd0, 10'd0);      idle_gap();
        send_command(OP_CLEAR, 16'h0000, 1'b0, 10'd0, 10'd0);      idle_gap();
        send_command(OP_ALLOC, 16'hFFFF, 1'b1, 10'h3FF, 10'd0);    idle_gap();
        send_command(OP_UNUSED, 16'h0000, 1'b0, 10'd0, 10'd0);     idle_gap();
        settle_pool();

        write_threshold(16'h0000);
        run_batch(BATCH_ITEMS);
        settle_pool();
        write_threshold(16'hFFFF);
        run_batch(BATCH_ITEMS);
        settle_pool();
        write_threshold(VALUE_W'($urandom_range(1, 16'hFFFE)));
        run_batch(BATCH_ITEMS);
        settle_pool();
        write_threshold(THRESHOLD_RESET);
        run_batch(BATCH_ITEMS);
        settle_pool();

        if (tracker.mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
